FILE: src/jets_pkg.sv
// shared types and constants for the julia escape-time pixel block
// no dependencies; used by every module under src

package jets_pkg;

  localparam int FRAC_BITS = 26;
  localparam int MAX_ITERS = 1024;
  localparam int MAX_SIDE  = 4096;

  localparam int FIX_W   = 32;
  localparam int PROD_W  = 2 * FIX_W;
  localparam int COORD_W = 12;
  localparam int CNT_W   = 11;
  localparam int SIDE_W  = 13;
  localparam int HALF_W  = SIDE_W - 1;
  localparam int GRAY_W  = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // dividend holds |p - h| scaled by 2^(FRAC_BITS+1), or count*255 for the gray level
  localparam int DVD_W = COORD_W + FRAC_BITS + 1;
  localparam int DEN_W = HALF_W;

  localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(4) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [FIX_W-1:0]  c_real;
    logic [FIX_W-1:0]  c_imag;
    logic [CNT_W-1:0]  iteration_limit;
    logic [SIDE_W-1:0] image_side;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [1:0] {
    REG_C_REAL,
    REG_C_IMAG,
    REG_ITER_LIMIT,
    REG_IMAGE_SIDE
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_WAITX,
    ST_DIVY,
    ST_WAITY,
    ST_SQRE,
    ST_SQIM,
    ST_TEST,
    ST_UPDATE,
    ST_GRAY,
    ST_WAITG,
    ST_HOLD
  } state_t;

endpackage

FILE: src/jets_regs.sv
// apb-style configuration registers: julia constant, iteration limit, image side
// depends on jets_pkg

module jets_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jets_pkg::ADDR_W-1:0]    paddr,
  input  logic [jets_pkg::DATA_W-1:0]    pwdata,
  output logic [jets_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output jets_pkg::cfg_t                 cfg
);

  jets_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = jets_pkg::reg_idx_t'(paddr[jets_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_real          <= '0;
      cfg.c_imag          <= '0;
      cfg.iteration_limit <= jets_pkg::CNT_W'(256);
      cfg.image_side      <= jets_pkg::SIDE_W'(1024);
    end else if (wr) begin
      case (idx)
        jets_pkg::REG_C_REAL:     cfg.c_real <= pwdata;
        jets_pkg::REG_C_IMAG:     cfg.c_imag <= pwdata;
        jets_pkg::REG_ITER_LIMIT: cfg.iteration_limit <= pwdata[jets_pkg::CNT_W-1:0];
        jets_pkg::REG_IMAGE_SIDE: cfg.image_side <= pwdata[jets_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      jets_pkg::REG_C_REAL:     prdata = cfg.c_real;
      jets_pkg::REG_C_IMAG:     prdata = cfg.c_imag;
      jets_pkg::REG_ITER_LIMIT:
        prdata = {{(jets_pkg::DATA_W-jets_pkg::CNT_W){1'b0}}, cfg.iteration_limit};
      jets_pkg::REG_IMAGE_SIDE:
        prdata = {{(jets_pkg::DATA_W-jets_pkg::SIDE_W){1'b0}}, cfg.image_side};
      default:                  prdata = '0;
    endcase
  end

endmodule

FILE: src/jets_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on jets_pkg; shared by the start-value and gray-level divisions

module jets_div (
  input  logic                         clk,
  input  logic                         rst,
  input  jets_pkg::div_req_t           req,
  output logic                         done,
  output logic [jets_pkg::DVD_W-1:0]   quot
);

  localparam int STEP_W = $clog2(jets_pkg::DVD_W + 1);

  logic                       busy;
  logic [STEP_W-1:0]          steps;
  logic [jets_pkg::DVD_W-1:0] dvd;
  logic [jets_pkg::DEN_W-1:0] rem;
  logic [jets_pkg::DEN_W-1:0] den;
  logic [jets_pkg::DEN_W:0]   trial;
  logic [jets_pkg::DEN_W:0]   trial_sub;
  logic                       fits;
  logic [jets_pkg::DEN_W-1:0] rem_next;

  assign trial     = {rem, dvd[jets_pkg::DVD_W-1]};
  assign trial_sub = trial - {1'b0, den};
  assign fits      = trial >= {1'b0, den};
  assign rem_next  = fits ? trial_sub[jets_pkg::DEN_W-1:0] : trial[jets_pkg::DEN_W-1:0];
  assign quot      = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(jets_pkg::DVD_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[jets_pkg::DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

FILE: src/jets_mul.sv
// shared signed 32x32 multiplier with registered 64-bit product
// depends on jets_pkg

module jets_mul (
  input  logic                               clk,
  input  logic signed [jets_pkg::FIX_W-1:0]  a,
  input  logic signed [jets_pkg::FIX_W-1:0]  b,
  output logic signed [jets_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: src/julia_escape_time_pixel.sv
// top level of the julia escape-time pixel evaluator
// depends on jets_pkg, jets_regs, jets_div, jets_mul

// One beat in carries a pixel (pixel_x, pixel_y) of a square image; one beat out
// carries its escape count, gray level and escape flag. The pixel is mapped to
// z = 2*(p-h)/h per axis (h = image_side/2) with a bit-serial divider (per axis:
// a start, 39 quotient bits, then the quotient is taken), then z = z*z + c is
// iterated in signed Q5.26 on one shared 32x32 multiplier: each step is re*im
// and the update, then re^2 and im^2 for the escape test, which also feed the
// next step; the final step skips the update. The gray level is a third pass
// through the divider. in_stall is high in every state but idle, from one
// accepted pixel beat until the sequencer is idle again; the result sits in an
// output register, so the next pixel may start while the previous result waits
// on out_stall.
// Limit 0 acts as 1, limit above 1024 as 1024; side below 2 acts as 2, above
// 4096 as 4096. Configuration is written over the apb-style port at byte
// addresses 0 (c_real), 4 (c_imag), 8 (iteration_limit), 12 (image_side) and
// must only change while no pixel is in flight.

module julia_escape_time_pixel (
  input  logic                             clk,
  input  logic                             rst,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jets_pkg::ADDR_W-1:0]      paddr,
  input  logic [jets_pkg::DATA_W-1:0]      pwdata,
  output logic [jets_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // pixel beats in
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [jets_pkg::COORD_W-1:0]     pixel_x,
  input  logic [jets_pkg::COORD_W-1:0]     pixel_y,
  // result beats out
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [jets_pkg::CNT_W-1:0]       iteration_count,
  output logic [jets_pkg::GRAY_W-1:0]      gray_level,
  output logic                             escaped
);

  localparam int FIX_W  = jets_pkg::FIX_W;
  localparam int PROD_W = jets_pkg::PROD_W;
  localparam int CNT_W  = jets_pkg::CNT_W;
  localparam int HALF_W = jets_pkg::HALF_W;
  localparam int DVD_W  = jets_pkg::DVD_W;

  jets_pkg::cfg_t     cfg;
  jets_pkg::state_t   state;
  jets_pkg::state_t   state_next;
  jets_pkg::div_req_t div_req;
  logic               div_done;
  logic [DVD_W-1:0]   div_quot;

  logic signed [FIX_W-1:0]  mul_a;
  logic signed [FIX_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // latched pixel and iteration state
  logic [jets_pkg::COORD_W-1:0] px;
  logic [jets_pkg::COORD_W-1:0] py;
  logic signed [FIX_W-1:0]      re;
  logic signed [FIX_W-1:0]      im;
  logic signed [PROD_W-1:0]     rr;
  logic signed [PROD_W-1:0]     ii;
  logic [CNT_W-1:0]             iter;
  logic [CNT_W-1:0]             cnt;
  logic                         esc;
  logic                         first;
  logic [jets_pkg::GRAY_W-1:0]  gray;

  // effective configuration
  logic [CNT_W-1:0]           lim;
  logic [jets_pkg::SIDE_W-1:0] side;
  logic [HALF_W-1:0]          half;

  logic                       in_take;
  logic                       out_free;
  logic signed [HALF_W:0]     dx;
  logic signed [HALF_W:0]     dy;
  logic [HALF_W-1:0]          dx_mag;
  logic [HALF_W-1:0]          dy_mag;
  logic [CNT_W+7:0]           cnt_x255;
  logic signed [PROD_W-1:0]   diff;
  logic signed [PROD_W-1:0]   nr_w;
  logic signed [PROD_W-1:0]   ni_w;
  logic [PROD_W-1:0]          mag;
  logic                       esc_hit;
  logic                       last_iter;

  // start value: truncated quotient, sign applied, clamped to q5.26
  function automatic logic [FIX_W-1:0] start_fix(input logic [DVD_W-1:0] q,
                                                 input logic neg);
    logic over_pos;
    logic over_neg;
    over_pos = |q[DVD_W-1:FIX_W-1];
    over_neg = (|q[DVD_W-1:FIX_W]) | (q[FIX_W-1] & (|q[FIX_W-2:0]));
    if (neg) begin
      start_fix = over_neg ? {1'b1, {(FIX_W-1){1'b0}}} : -q[FIX_W-1:0];
    end else begin
      start_fix = over_pos ? {1'b0, {(FIX_W-1){1'b1}}} : q[FIX_W-1:0];
    end
  endfunction

  // clamp a wide signed value to q5.26
  function automatic logic [FIX_W-1:0] sat_fix(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:FIX_W-1] == {(PROD_W-FIX_W+1){v[PROD_W-1]}}) begin
      sat_fix = v[FIX_W-1:0];
    end else begin
      sat_fix = v[PROD_W-1] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    end
  endfunction

  jets_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jets_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  jets_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // clamp limit and side into their supported ranges
  always_comb begin
    if (cfg.iteration_limit == '0) begin
      lim = CNT_W'(1);
    end else if (cfg.iteration_limit > CNT_W'(jets_pkg::MAX_ITERS)) begin
      lim = CNT_W'(jets_pkg::MAX_ITERS);
    end else begin
      lim = cfg.iteration_limit;
    end
    if (cfg.image_side < jets_pkg::SIDE_W'(2)) begin
      side = jets_pkg::SIDE_W'(2);
    end else if (cfg.image_side > jets_pkg::SIDE_W'(jets_pkg::MAX_SIDE)) begin
      side = jets_pkg::SIDE_W'(jets_pkg::MAX_SIDE);
    end else begin
      side = cfg.image_side;
    end
  end

  assign half = side[jets_pkg::SIDE_W-1:1];

  // offsets from the image center, as sign and magnitude for the divider
  assign dx     = signed'({1'b0, px}) - signed'({1'b0, half});
  assign dy     = signed'({1'b0, py}) - signed'({1'b0, half});
  assign dx_mag = dx[HALF_W] ? HALF_W'(-dx) : dx[HALF_W-1:0];
  assign dy_mag = dy[HALF_W] ? HALF_W'(-dy) : dy[HALF_W-1:0];

  // count * 255 as a shift and subtract
  assign cnt_x255 = {cnt, 8'b0} - {8'b0, cnt};

  // one step of z*z + c from registered squares and cross product
  // the constants are sign-extended as signed so the shifts stay arithmetic
  assign diff = rr - ii;
  assign nr_w = (diff >>> jets_pkg::FRAC_BITS)
                + $signed({{(PROD_W-FIX_W){cfg.c_real[FIX_W-1]}}, cfg.c_real});
  assign ni_w = (prod >>> (jets_pkg::FRAC_BITS - 1))
                + $signed({{(PROD_W-FIX_W){cfg.c_imag[FIX_W-1]}}, cfg.c_imag});

  // escape test: re^2 sits in rr, im^2 arrives on the multiplier output
  assign mag       = $unsigned(rr) + $unsigned(prod);
  assign esc_hit   = mag > jets_pkg::ESC_BOUND;
  assign last_iter = (iter + CNT_W'(1)) == lim;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      jets_pkg::ST_IDLE:   if (in_valid) state_next = jets_pkg::ST_DIVX;
      jets_pkg::ST_DIVX:   state_next = jets_pkg::ST_WAITX;
      jets_pkg::ST_WAITX:  if (div_done) state_next = jets_pkg::ST_DIVY;
      jets_pkg::ST_DIVY:   state_next = jets_pkg::ST_WAITY;
      jets_pkg::ST_WAITY:  if (div_done) state_next = jets_pkg::ST_SQRE;
      jets_pkg::ST_SQRE:   state_next = jets_pkg::ST_SQIM;
      jets_pkg::ST_SQIM:   state_next = jets_pkg::ST_TEST;
      jets_pkg::ST_TEST: begin
        if (!first && (esc_hit || last_iter)) begin
          state_next = jets_pkg::ST_GRAY;
        end else begin
          state_next = jets_pkg::ST_UPDATE;
        end
      end
      jets_pkg::ST_UPDATE: state_next = jets_pkg::ST_SQRE;
      jets_pkg::ST_GRAY:   state_next = jets_pkg::ST_WAITG;
      jets_pkg::ST_WAITG:  if (div_done) state_next = jets_pkg::ST_HOLD;
      jets_pkg::ST_HOLD:   if (out_free) state_next = jets_pkg::ST_IDLE;
      default:             state_next = jets_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider request, multiplier operands
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = {{(DVD_W-CNT_W-8){1'b0}}, cnt_x255};
    div_req.divisor  = {{(HALF_W-CNT_W){1'b0}}, lim};
    mul_a            = re;
    mul_b            = im;
    case (state)
      jets_pkg::ST_IDLE: in_stall = 1'b0;
      jets_pkg::ST_DIVX: begin
        div_req.start    = 1'b1;
        div_req.dividend = {dx_mag, {(jets_pkg::FRAC_BITS+1){1'b0}}};
        div_req.divisor  = half;
      end
      jets_pkg::ST_DIVY: begin
        div_req.start    = 1'b1;
        div_req.dividend = {dy_mag, {(jets_pkg::FRAC_BITS+1){1'b0}}};
        div_req.divisor  = half;
      end
      jets_pkg::ST_SQRE: begin
        mul_a = re;
        mul_b = re;
      end
      jets_pkg::ST_SQIM: begin
        mul_a = im;
        mul_b = im;
      end
      jets_pkg::ST_GRAY: div_req.start = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jets_pkg::ST_IDLE;
      out_valid <= 1'b0;
      first     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        first <= 1'b1;
      end else if (state == jets_pkg::ST_TEST) begin
        first <= 1'b0;
      end
      if (state == jets_pkg::ST_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      jets_pkg::ST_IDLE: begin
        if (in_take) begin
          px   <= pixel_x;
          py   <= pixel_y;
          iter <= '0;
        end
      end
      jets_pkg::ST_WAITX: if (div_done) re <= start_fix(div_quot, dx[HALF_W]);
      jets_pkg::ST_WAITY: if (div_done) im <= start_fix(div_quot, dy[HALF_W]);
      jets_pkg::ST_SQIM:  rr <= prod;
      jets_pkg::ST_TEST: begin
        ii <= prod;
        if (!first) begin
          if (esc_hit) begin
            cnt <= iter;
            esc <= 1'b1;
          end else if (last_iter) begin
            cnt <= lim;
            esc <= 1'b0;
          end else begin
            iter <= iter + CNT_W'(1);
          end
        end
      end
      jets_pkg::ST_UPDATE: begin
        re <= sat_fix(nr_w);
        im <= sat_fix(ni_w);
      end
      jets_pkg::ST_WAITG: if (div_done) gray <= div_quot[jets_pkg::GRAY_W-1:0];
      jets_pkg::ST_HOLD: begin
        if (out_free) begin
          iteration_count <= cnt;
          gray_level      <= gray;
          escaped         <= esc;
        end
      end
      default: ;
    endcase
  end

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == jets_pkg::ST_WAITX || state == jets_pkg::ST_WAITY ||
                  state == jets_pkg::ST_WAITG))
    else $error("divider finished outside a wait state");

  // a new result beat only appears out of the hold state
  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == jets_pkg::ST_HOLD))
    else $error("result beat raised outside the hold state");

  // a finished pixel cannot leave hold while the previous beat is still stalled
  a_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (state == jets_pkg::ST_HOLD && out_valid && out_stall) |=>
      (state == jets_pkg::ST_HOLD))
    else $error("hold state left while the output register was busy");

endmodule
